// ----- src/cvbs_pkg.sv -----
// Shared types and constants for the closest-value table search.
`default_nettype none
package cvbs_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned COUNT_W = 9;
  localparam logic        MODE_WRITE = 1'b0;
  localparam logic        MODE_QUERY = 1'b1;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic        [INDEX_W-1:0] index_t;
  typedef logic        [COUNT_W-1:0] count_t;

  // Comparison of the search target against one table entry.
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

  function automatic cmp_t compare_target(value_t target, value_t entry);
    cmp_t c;
    c.lt = (target < entry);
    c.eq = (target == entry);
    return c;
  endfunction

  // Upper neighbour wins when target - lo >= hi - target, i.e. 2*target - lo - hi >= 0.
  function automatic value_t nearer_of(value_t lo, value_t hi, value_t target);
    logic signed [VALUE_W+1:0] diff;
    diff = ({{1{target[VALUE_W-1]}}, target, 1'b0})
           - {{2{lo[VALUE_W-1]}}, lo} - {{2{hi[VALUE_W-1]}}, hi};
    return diff[VALUE_W+1] ? lo : hi;
  endfunction

endpackage
`default_nettype wire

// ----- src/cvbs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cvbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]        wr_addr,
  input  wire logic [WIDTH-1:0]                wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]        rd_addr,
  output logic      [WIDTH-1:0]                rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- src/closest_value_binary_search_top.sv -----
// Top level: entry table and binary-search sequencer for the closest stored value.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | in_mode, in_entry_index, in_value
//  out_    | output    | out_valid/out_stall | out_closest_value
//  cfg_    | input     | cfg_wr_en           | cfg_wr_data (entry_count)
//
// A write item is taken while the sequencer is idle. A query first checks both ends of
// the table, then does one table read per probe plus one more read when a neighbour is
// checked, then a tie decision step and an output load step.
// Each compare step of a query is one read of the single table port and one compare.
// Reset is synchronous and active low; it sets entry_count to 1, table contents stay.
// A stalled result holds in the output register; the sequencer waits until it can load.
`default_nettype none
module closest_value_binary_search_top #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_mode,
  input  wire cvbs_pkg::index_t         in_entry_index,
  input  wire cvbs_pkg::value_t         in_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output cvbs_pkg::value_t              out_closest_value,
  input  wire logic                     cfg_wr_en,
  input  wire cvbs_pkg::count_t         cfg_wr_data
);

  import cvbs_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int unsigned EW = (AW > INDEX_W) ? AW : INDEX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP_FIRST,
    S_CMP_LAST,
    S_CMP_PROBE,
    S_CMP_LO,
    S_CMP_HI,
    S_NEAR,
    S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  count_t          entry_count_r;
  value_t          target_r, target_nxt;
  value_t          probe_r, probe_nxt;
  value_t          lo_r, lo_nxt;
  value_t          hi_r, hi_nxt;
  value_t          res_r, res_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [AW-1:0]   mid_r, mid_nxt;
  logic            out_valid_r, out_valid_nxt;
  value_t          out_value_r, out_value_nxt;

  logic            accept;
  logic [EW:0]     idx_ext;
  logic            wr_en;
  logic [AW-1:0]   rd_addr;
  logic [VALUE_W-1:0] rd_raw;
  value_t          rd_data;
  cmp_t            cmp;
  logic [NW-1:0]   cnt_ext;
  logic [CW-1:0]   n_eff;
  logic [CW:0]     mid_sum;
  logic            loop_go;
  logic [CW-1:0]   mid_plus1;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign idx_ext  = (EW+1)'(in_entry_index);
  assign wr_en    = accept && (in_mode == MODE_WRITE) && (idx_ext < (EW+1)'(TABLE_DEPTH));

  cvbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data (in_value),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_data = value_t'(rd_raw);
  // shared compare unit: target against whatever the table port returned
  assign cmp     = compare_target(target_r, rd_data);

  // count of zero acts as one, counts beyond the depth saturate
  always_comb begin
    cnt_ext = NW'(entry_count_r);
    if (cnt_ext == '0) begin
      n_eff = CW'(1);
    end else if (cnt_ext > NW'(TABLE_DEPTH)) begin
      n_eff = CW'(TABLE_DEPTH);
    end else begin
      n_eff = cnt_ext[CW-1:0];
    end
  end

  assign mid_plus1 = CW'(mid_r) + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    target_nxt    = target_r;
    probe_nxt     = probe_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    res_nxt       = res_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    mid_nxt       = mid_r;
    rd_addr       = mid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    loop_go       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (accept && (in_mode == MODE_QUERY)) begin
          target_nxt = in_value;
          n_nxt      = n_eff;
          state_nxt  = S_CMP_FIRST;
        end
      end
      S_CMP_FIRST: begin
        rd_addr = AW'(n_r - CW'(1));
        if (cmp.lt || cmp.eq) begin
          res_nxt   = rd_data;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_CMP_LAST;
        end
      end
      S_CMP_LAST: begin
        if (!cmp.lt) begin
          res_nxt   = rd_data;
          state_nxt = S_EMIT;
        end else begin
          i_nxt   = '0;
          j_nxt   = n_r;
          loop_go = 1'b1;
        end
      end
      S_CMP_PROBE: begin
        probe_nxt = rd_data;
        if (cmp.eq) begin
          res_nxt   = rd_data;
          state_nxt = S_EMIT;
        end else if (cmp.lt) begin
          if (mid_r != '0) begin
            rd_addr   = mid_r - AW'(1);
            hi_nxt    = rd_data;
            state_nxt = S_CMP_LO;
          end else begin
            j_nxt   = CW'(mid_r);
            loop_go = 1'b1;
          end
        end else begin
          if (mid_plus1 < n_r) begin
            rd_addr   = mid_plus1[AW-1:0];
            lo_nxt    = rd_data;
            state_nxt = S_CMP_HI;
          end else begin
            i_nxt   = mid_plus1;
            loop_go = 1'b1;
          end
        end
        // loop exit falls back to this probe
        res_nxt = (loop_go || cmp.eq) ? rd_data : res_r;
      end
      S_CMP_LO: begin
        res_nxt = probe_r;
        if (!cmp.lt && !cmp.eq) begin
          lo_nxt    = rd_data;
          state_nxt = S_NEAR;
        end else begin
          j_nxt   = CW'(mid_r);
          loop_go = 1'b1;
        end
      end
      S_CMP_HI: begin
        res_nxt = probe_r;
        if (cmp.lt) begin
          hi_nxt    = rd_data;
          state_nxt = S_NEAR;
        end else begin
          i_nxt   = mid_plus1;
          loop_go = 1'b1;
        end
      end
      S_NEAR: begin
        res_nxt   = nearer_of(lo_r, hi_r, target_r);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    mid_sum = (CW+1)'(i_nxt) + (CW+1)'(j_nxt);
    if (loop_go) begin
      if (i_nxt < j_nxt) begin
        mid_nxt   = mid_sum[AW:1];
        rd_addr   = mid_sum[AW:1];
        state_nxt = S_CMP_PROBE;
      end else begin
        state_nxt = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= COUNT_W'(1);
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        entry_count_r <= cfg_wr_data;
      end
    end
    target_r    <= target_nxt;
    probe_r     <= probe_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    res_r       <= res_nxt;
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    mid_r       <= mid_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_closest_value = out_value_r;

endmodule
`default_nettype wire

// ----- dv/tb_closest_value_binary_search_top.sv -----
// Testbench for the closest-value table search: directed and random traffic, local predictor.
`timescale 1ns / 1ps
module tb_closest_value_binary_search_top;
  import cvbs_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 256;
  localparam int unsigned RANDOM_ITEMS  = 1200;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned PRINT_LIMIT   = 50;
  localparam value_t      Q_MIN         = 32'sh8000_0000;
  localparam value_t      Q_MAX         = 32'sh7FFF_FFFF;
  localparam value_t      Q_ONE         = 32'sh0001_0000;

  typedef enum int unsigned {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
  } stall_style_t;
  typedef enum int unsigned {
    TGT_EXACT, TGT_NEAR, TGT_MIDPOINT, TGT_ANY, TGT_EXTREME
  } target_kind_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  logic   in_mode;
  index_t in_entry_index;
  value_t in_value;
  logic   out_valid;
  logic   out_stall;
  value_t out_closest_value;
  logic   cfg_wr_en;
  count_t cfg_wr_data;

  // Local copy of the block state
  value_t      stored_entry [TABLE_DEPTH];
  count_t      entry_count_cfg;
  value_t      expected_closest [$];
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned burst_left;
  logic        sender_gappy;
  logic        long_hold_req;

  closest_value_binary_search_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_entry_index   (in_entry_index),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_closest_value(out_closest_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned active_entries();
    if (entry_count_cfg == 0) return 1;
    if (entry_count_cfg > TABLE_DEPTH) return TABLE_DEPTH;
    return entry_count_cfg;
  endfunction

  // Upper neighbour wins when the distances are equal.
  function automatic value_t upper_if_tie(int unsigned lo_idx, int unsigned hi_idx, longint t);
    longint lo_v;
    longint hi_v;
    lo_v = stored_entry[lo_idx];
    hi_v = stored_entry[hi_idx];
    return (t - lo_v >= hi_v - t) ? stored_entry[hi_idx] : stored_entry[lo_idx];
  endfunction

  function automatic value_t predict_closest(value_t target);
    longint      t;
    longint      probe;
    int unsigned n;
    int unsigned i;
    int unsigned j;
    int unsigned mid;
    n = active_entries();
    t = target;
    if (t <= longint'(stored_entry[0])) return stored_entry[0];
    if (t >= longint'(stored_entry[n-1])) return stored_entry[n-1];
    i = 0;
    j = n;
    mid = 0;
    while (i < j) begin
      mid = (i + j) / 2;
      probe = stored_entry[mid];
      if (probe == t) return stored_entry[mid];
      if (t < probe) begin
        if (mid > 0 && t > longint'(stored_entry[mid-1]))
          return upper_if_tie(mid - 1, mid, t);
        j = mid;
      end else begin
        if (mid + 1 < n && t < longint'(stored_entry[mid+1]))
          return upper_if_tie(mid, mid + 1, t);
        i = mid + 1;
      end
    end
    return stored_entry[mid];
  endfunction

  task automatic report_mismatch(input string what, input value_t got, input value_t want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // Offer one item, hold it until the transfer, then apply the sender's gap pattern.
  task automatic send_item(input logic mode, input index_t idx, input value_t val);
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_entry_index <= idx;
    in_value       <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (mode == MODE_WRITE) stored_entry[idx] = val;
    else expected_closest = {expected_closest, predict_closest(val)};
    items_sent++;
    if (sender_gappy) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drain every result, then let a trailing table write finish.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_closest.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input count_t cnt);
    settle_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cnt;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    entry_count_cfg = cnt;
  endtask

  task automatic load_sorted_table(input int unsigned n, input logic pin_extremes);
    int          vals [$];
    int unsigned k;
    int unsigned style;
    style = $urandom_range(0, 2);
    for (k = 0; k < n; k++) begin
      case (style)
        0:       vals = {vals, int'($urandom)};
        1:       vals = {vals, int'($urandom_range(0, 1000)) - 500};  // duplicates and ties
        default: vals = {vals, int'($urandom) >>> $urandom_range(0, 24)};
      endcase
    end
    vals.sort();
    if (pin_extremes) begin
      vals[0]   = Q_MIN;
      vals[n-1] = Q_MAX;
    end
    for (k = 0; k < n; k++) send_item(MODE_WRITE, index_t'(k), value_t'(vals[k]));
  endtask

  function automatic value_t pick_target(int unsigned n);
    int unsigned k;
    longint      s;
    k = $urandom_range(0, n - 1);
    case (target_kind_t'($urandom_range(TGT_EXACT, TGT_EXTREME)))
      TGT_EXACT: return stored_entry[k];
      TGT_NEAR: begin
        s = stored_entry[k];
        return value_t'(s + $urandom_range(0, 6) - 3);
      end
      TGT_MIDPOINT: begin
        if (k + 1 >= n) return stored_entry[k];
        s = stored_entry[k];
        s = s + stored_entry[k+1];
        return value_t'((s >>> 1) + $urandom_range(0, 1));
      end
      TGT_ANY: return value_t'($urandom);
      default: return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
    endcase
  endfunction

  // Results, oldest expectation first
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_closest.size() == 0)
        report_mismatch("result with nothing outstanding", out_closest_value, 'x);
      else if (out_closest_value !== expected_closest[0])
        report_mismatch("closest_value", out_closest_value, expected_closest.pop_front());
      else
        void'(expected_closest.pop_front());
    end
  end

  // Receiver: stall styles of random duration, plus one long hold on request.
  initial begin
    stall_style_t style;
    int unsigned  style_left;
    int unsigned  cyc;
    out_stall  = 1'b0;
    style      = STALL_NONE;
    style_left = 0;
    cyc        = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = stall_style_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
          style_left = $urandom_range(64, 512);
        end
        style_left--;
        case (style)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ((cyc % 7) < 3);
        endcase
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Count out of reset is one entry, so only entry zero is searched.
  task automatic test_reset_count();
    value_t e0;
    e0 = value_t'($urandom);
    send_item(MODE_WRITE, index_t'(0), e0);
    send_item(MODE_WRITE, index_t'(TABLE_DEPTH - 1), value_t'($urandom));
    send_item(MODE_QUERY, index_t'(0), Q_MIN);
    send_item(MODE_QUERY, index_t'(0), e0);
    send_item(MODE_QUERY, index_t'(TABLE_DEPTH - 1), Q_MAX);
  endtask

  task automatic test_full_table();
    value_t mid_a;
    value_t mid_b;
    longint s;
    write_count(count_t'(TABLE_DEPTH));
    load_sorted_table(TABLE_DEPTH, 1'b1);
    mid_a = stored_entry[100];
    mid_b = stored_entry[101];
    s = longint'(mid_a) + longint'(mid_b);
    send_item(MODE_QUERY, index_t'(0), Q_MIN);
    send_item(MODE_QUERY, index_t'(0), Q_MAX);
    send_item(MODE_QUERY, index_t'(0), stored_entry[77]);
    send_item(MODE_QUERY, index_t'(0), value_t'(s >>> 1));
  endtask

  task automatic test_tie_break();
    int unsigned k;
    write_count(count_t'(5));
    for (k = 0; k < 5; k++) send_item(MODE_WRITE, index_t'(k), value_t'(k * 10));
    send_item(MODE_QUERY, index_t'(0), value_t'(15));  // equal distance, upper wins
    send_item(MODE_QUERY, index_t'(0), value_t'(14));
    send_item(MODE_QUERY, index_t'(0), value_t'(-5));
    send_item(MODE_QUERY, index_t'(0), value_t'(41));
    // widest possible gap: distances of 2^31 and 2^31-1
    write_count(count_t'(2));
    send_item(MODE_WRITE, index_t'(0), Q_MIN);
    send_item(MODE_WRITE, index_t'(1), Q_MAX);
    send_item(MODE_QUERY, index_t'(0), value_t'(0));
    send_item(MODE_QUERY, index_t'(0), value_t'(-1));
  endtask

  task automatic test_count_limits();
    write_count(count_t'(0));
    send_item(MODE_QUERY, index_t'(0), Q_ONE);
    write_count(count_t'(300));
    send_item(MODE_QUERY, index_t'(0), value_t'(Q_MAX - 1));
    write_count(count_t'(511));
    send_item(MODE_QUERY, index_t'(0), Q_MAX);
  endtask

  task automatic test_unsorted();
    int unsigned k;
    write_count(count_t'(4));
    for (k = 0; k < 4; k++) send_item(MODE_WRITE, index_t'(k), value_t'((3 - k) * Q_ONE));
    send_item(MODE_QUERY, index_t'(0), value_t'(Q_ONE + (Q_ONE >>> 1)));
    send_item(MODE_QUERY, index_t'(0), value_t'(-Q_ONE));
  endtask

  // Hold results off for a long stretch while queries keep coming.
  task automatic test_backpressure();
    write_count(count_t'(64));
    load_sorted_table(64, 1'b0);
    sender_gappy  = 1'b0;
    long_hold_req = 1'b1;
    repeat (40) send_item(MODE_QUERY, index_t'($urandom_range(0, 255)), pick_target(64));
  endtask

  task automatic test_random_rounds();
    int unsigned stop_at;
    int unsigned n;
    int unsigned k;
    count_t      cnt;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0:       cnt = count_t'(0);
        1:       cnt = count_t'(TABLE_DEPTH);
        2:       cnt = count_t'($urandom_range(TABLE_DEPTH + 1, 511));
        3:       cnt = count_t'($urandom_range(17, TABLE_DEPTH - 1));
        default: cnt = count_t'($urandom_range(1, 16));
      endcase
      write_count(cnt);
      n = active_entries();
      sender_gappy = ($urandom_range(0, 3) != 0);
      if (n <= 32 || $urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 4) == 0)
          for (k = 0; k < n; k++) send_item(MODE_WRITE, index_t'(k), value_t'($urandom));
        else
          load_sorted_table(n, 1'b0);
      end
      repeat ($urandom_range(40, 120)) begin
        if ($urandom_range(0, 19) == 0)
          send_item(MODE_WRITE, index_t'($urandom_range(0, 255)), value_t'($urandom));
        else
          send_item(MODE_QUERY, index_t'($urandom_range(0, 255)), pick_target(n));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_WRITE;
    in_entry_index = '0;
    in_value       = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    long_hold_req  = 1'b0;
    sender_gappy   = 1'b1;
    burst_left     = 0;
    error_count    = 0;
    items_sent     = 0;
    entry_count_cfg = count_t'(1);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_count();
    test_full_table();
    test_tie_break();
    test_count_limits();
    test_unsorted();
    test_backpressure();
    test_random_rounds();
    settle_block();

    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
